// File: rtl/core/assert_macros.svh
// assertion macros shared by the rtl
// no dependencies; expects a clock named clk and a reset named rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge outside reset
`define ASSERT_IMPL(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// implication whose right side is checked in the next cycle
`define ASSERT_NEXT(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

// File: rtl/core/ttc_pkg.sv
// types and constants of the tile texture cache lookup
// no dependencies
package ttc_pkg;

  localparam int FUNC_W  = 2;
  localparam int COORD_W = 16;
  localparam int TILE_W  = 15;
  localparam int TEX_W   = 7;
  localparam int LSLOT_W = 6;
  localparam int LOG_W   = 4;
  localparam int STAMP_W = 32;
  localparam int ROW_TILES_LOG2 = 5;
  localparam logic [STAMP_W-1:0] FRAME_RESET = 32'd100;
  localparam logic [LOG_W-1:0] LOG2_RESET = 4'd8;

  typedef enum logic [FUNC_W-1:0] {
    FN_LOOKUP = 2'd0,
    FN_TICK   = 2'd1,
    FN_DONE   = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  typedef enum logic {
    REG_WIDTH_LOG2  = 1'b0,
    REG_HEIGHT_LOG2 = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_TRD, ST_TCHK, ST_SCAN,
    ST_EVRD, ST_EVCLR, ST_ALLOC, ST_OUT
  } state_t;

endpackage

// File: rtl/core/ttc_req_if.sv
// request channel: valid, ready and one input word
// depends on ttc_pkg
interface ttc_req_if;
  logic                              valid;
  logic                              ready;
  logic [ttc_pkg::FUNC_W-1:0]        func;
  logic signed [ttc_pkg::COORD_W-1:0] map_x;
  logic signed [ttc_pkg::COORD_W-1:0] map_y;
  logic [ttc_pkg::LSLOT_W-1:0]       done_slot;
  modport source (output valid, func, map_x, map_y, done_slot, input ready);
  modport sink (input valid, func, map_x, map_y, done_slot, output ready);
endinterface

// File: rtl/core/ttc_rsp_if.sv
// response channel: valid, ready and one result word
// depends on ttc_pkg
interface ttc_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ttc_pkg::TEX_W-1:0]    texture_number;
  logic                         is_hires;
  logic                         load_request;
  logic [ttc_pkg::LSLOT_W-1:0]  load_slot;
  logic [ttc_pkg::TILE_W-1:0]   load_tile_x;
  logic [ttc_pkg::TILE_W-1:0]   load_tile_y;
  logic                         evicted;
  modport source (output valid, texture_number, is_hires, load_request, load_slot,
                  load_tile_x, load_tile_y, evicted, input ready);
  modport sink (input valid, texture_number, is_hires, load_request, load_slot,
                load_tile_x, load_tile_y, evicted, output ready);
endinterface

// File: rtl/core/tile_texture_cache_lookup_top.sv
// tile texture cache lookup: a hit passes TRD, TCHK and OUT, a miss with a free slot
// TRD, TCHK, ALLOC and OUT, a miss that evicts TRD, TCHK, a slot stamp scan, EVRD, EVCLR,
// ALLOC and OUT; tick and load-done words are done in IDLE; one word is worked on at a time
// after reset a clearing pass writes every tile table entry, during which no word is
// accepted; config writes are taken always
module tile_texture_cache_lookup_top #(
  parameter int NUM_SLOTS = 64,
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [ttc_pkg::LOG_W-1:0] cfg_data,
  ttc_req_if.sink     req_ch,
  ttc_rsp_if.source   rsp_ch
);
  `include "assert_macros.svh"

  localparam int SW = $clog2(NUM_SLOTS);
  localparam int TW = $clog2(TABLE_ENTRIES);
  localparam int SUM_W = ttc_pkg::TILE_W + ttc_pkg::ROW_TILES_LOG2 + 1;

  ttc_pkg::state_t state, state_next;

  logic [ttc_pkg::LOG_W-1:0]   wl, hl;
  logic [ttc_pkg::STAMP_W-1:0] frame;
  logic [NUM_SLOTS-1:0]        slot_valid, slot_ready;
  logic [TW-1:0]               clr_idx;

  logic                        neg_q;
  logic [TW-1:0]               tile_q;
  logic [ttc_pkg::TILE_W-1:0]  tx_q, ty_q;
  logic [3:0]                  coarse_q;
  logic [SW-1:0]               slot_q, best_q, scan_idx;
  logic                        best_found;
  logic [ttc_pkg::STAMP_W-1:0] limit_q;
  logic                        hires_q, req_q, ev_q;

  logic                        tbl_we;
  logic [TW-1:0]               tbl_waddr, tbl_raddr;
  logic [SW:0]                 tbl_wdata, tbl_rdata;
  logic                        stamp_we, tile_we;
  logic [SW-1:0]               stamp_waddr, stamp_raddr;
  logic [ttc_pkg::STAMP_W-1:0] stamp_rdata;
  logic [TW-1:0]               tile_rdata;

  logic                        any_free;
  logic [SW-1:0]               free_idx;
  logic [ttc_pkg::TILE_W-1:0]  x_in, y_in, tx_in, ty_in;
  logic [3:0]                  shift_in;
  logic [SUM_W-1:0]            tile_sum;
  logic [ttc_pkg::TILE_W+1:0]  cx4, cy4, cx, cy;
  logic                        scan_last;

  ttc_tile_tbl #(.TABLE_ENTRIES(TABLE_ENTRIES), .SW(SW)) u_tbl (
    .clk, .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .raddr(tbl_raddr), .rdata(tbl_rdata)
  );

  ttc_slot_mem #(.NUM_SLOTS(NUM_SLOTS), .TW(TW)) u_slot (
    .clk,
    .stamp_we, .stamp_waddr, .stamp_wdata(frame), .stamp_raddr, .stamp_rdata,
    .tile_we, .tile_waddr(slot_q), .tile_wdata(tile_q), .tile_raddr(best_q),
    .tile_rdata
  );

  // address math for an incoming lookup
  always_comb begin
    x_in     = req_ch.map_x[ttc_pkg::TILE_W-1:0];
    y_in     = req_ch.map_y[ttc_pkg::TILE_W-1:0];
    shift_in = (wl >= 4'd5) ? wl - 4'd5 : 4'd0;
    tx_in    = x_in >> shift_in;
    ty_in    = y_in >> shift_in;
    tile_sum = {1'b0, ty_in, 5'b0} + SUM_W'(tx_in);
    cx4      = {x_in, 2'b0};
    cy4      = {y_in, 2'b0};
    cx       = cx4 >> wl;
    cy       = cy4 >> hl;
  end

  // first empty slot
  always_comb begin
    any_free = ~&slot_valid;
    free_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_idx = SW'(i);
      end
    end
  end

  assign scan_last = (scan_idx == SW'(NUM_SLOTS - 1));

  always_comb begin
    state_next  = state;
    req_ch.ready = 1'b0;
    tbl_we      = 1'b0;
    tbl_waddr   = tile_q;
    tbl_wdata   = {1'b1, slot_q};
    tbl_raddr   = tile_q;
    stamp_we    = 1'b0;
    stamp_waddr = slot_q;
    stamp_raddr = '0;
    tile_we     = 1'b0;
    unique case (state)
      ttc_pkg::ST_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_idx;
        tbl_wdata = '0;
        if (clr_idx == TW'(TABLE_ENTRIES - 1)) begin
          state_next = ttc_pkg::ST_IDLE;
        end
      end
      ttc_pkg::ST_IDLE: begin
        req_ch.ready = 1'b1;
        if (req_ch.valid && req_ch.func == ttc_pkg::FN_LOOKUP) begin
          state_next = (req_ch.map_x[15] || req_ch.map_y[15]) ? ttc_pkg::ST_OUT
                                                              : ttc_pkg::ST_TRD;
        end
      end
      ttc_pkg::ST_TRD: begin
        state_next = ttc_pkg::ST_TCHK;
      end
      ttc_pkg::ST_TCHK: begin
        if (tbl_rdata[SW]) begin
          stamp_we    = 1'b1;
          stamp_waddr = tbl_rdata[SW-1:0];
          state_next  = ttc_pkg::ST_OUT;
        end else if (any_free) begin
          state_next = ttc_pkg::ST_ALLOC;
        end else begin
          stamp_raddr = '0;
          state_next  = ttc_pkg::ST_SCAN;
        end
      end
      ttc_pkg::ST_SCAN: begin
        stamp_raddr = scan_idx + SW'(1);
        if (scan_last) begin
          state_next = (best_found || stamp_rdata < limit_q) ? ttc_pkg::ST_EVRD
                                                             : ttc_pkg::ST_OUT;
        end
      end
      ttc_pkg::ST_EVRD: begin
        state_next = ttc_pkg::ST_EVCLR;
      end
      ttc_pkg::ST_EVCLR: begin
        tbl_we     = 1'b1;
        tbl_waddr  = tile_rdata;
        tbl_wdata  = '0;
        state_next = ttc_pkg::ST_ALLOC;
      end
      ttc_pkg::ST_ALLOC: begin
        tbl_we     = 1'b1;
        stamp_we   = 1'b1;
        tile_we    = 1'b1;
        state_next = ttc_pkg::ST_OUT;
      end
      ttc_pkg::ST_OUT: begin
        if (!rsp_ch.valid || rsp_ch.ready) begin
          state_next = ttc_pkg::ST_IDLE;
        end
      end
      default: state_next = ttc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttc_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wl <= ttc_pkg::LOG2_RESET;
      hl <= ttc_pkg::LOG2_RESET;
    end else if (cfg_we) begin
      unique case (ttc_pkg::reg_idx_t'(cfg_index))
        ttc_pkg::REG_WIDTH_LOG2:  wl <= cfg_data;
        ttc_pkg::REG_HEIGHT_LOG2: hl <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame      <= ttc_pkg::FRAME_RESET;
      slot_valid <= '0;
      slot_ready <= '0;
      clr_idx    <= '0;
      rsp_ch.valid <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready && state != ttc_pkg::ST_OUT) begin
        rsp_ch.valid <= 1'b0;
      end
      unique case (state)
        ttc_pkg::ST_CLEAR: begin
          clr_idx <= clr_idx + TW'(1);
        end
        ttc_pkg::ST_IDLE: begin
          if (req_ch.valid) begin
            neg_q    <= req_ch.map_x[15] || req_ch.map_y[15];
            tile_q   <= tile_sum[TW-1:0];
            tx_q     <= tx_in;
            ty_q     <= ty_in;
            coarse_q <= 4'({cy[1:0], 2'b0} + cx[3:0]);
            hires_q  <= 1'b0;
            req_q    <= 1'b0;
            ev_q     <= 1'b0;
            unique case (ttc_pkg::func_t'(req_ch.func))
              ttc_pkg::FN_TICK: frame <= frame + 32'd1;
              ttc_pkg::FN_DONE: begin
                if (32'(req_ch.done_slot) < 32'(NUM_SLOTS)
                    && slot_valid[SW'(req_ch.done_slot)]) begin
                  slot_ready[SW'(req_ch.done_slot)] <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        ttc_pkg::ST_TCHK: begin
          best_found <= 1'b0;
          limit_q    <= frame - 32'd2;
          scan_idx   <= '0;
          if (tbl_rdata[SW]) begin
            slot_q  <= tbl_rdata[SW-1:0];
            hires_q <= slot_ready[tbl_rdata[SW-1:0]];
          end else begin
            slot_q <= free_idx;
          end
        end
        ttc_pkg::ST_SCAN: begin
          scan_idx <= scan_idx + SW'(1);
          if (stamp_rdata < limit_q) begin
            limit_q    <= stamp_rdata;
            best_q     <= scan_idx;
            best_found <= 1'b1;
          end
        end
        ttc_pkg::ST_EVRD: begin
          slot_q <= best_q;
        end
        ttc_pkg::ST_EVCLR: begin
          ev_q <= 1'b1;
        end
        ttc_pkg::ST_ALLOC: begin
          slot_valid[slot_q] <= 1'b1;
          slot_ready[slot_q] <= 1'b0;
          req_q              <= 1'b1;
        end
        ttc_pkg::ST_OUT: begin
          if (!rsp_ch.valid || rsp_ch.ready) begin
            rsp_ch.valid          <= 1'b1;
            rsp_ch.is_hires       <= hires_q && !neg_q;
            rsp_ch.load_request   <= req_q;
            rsp_ch.evicted        <= ev_q;
            rsp_ch.load_slot      <= req_q ? ttc_pkg::LSLOT_W'(slot_q) : '0;
            rsp_ch.load_tile_x    <= req_q ? tx_q : '0;
            rsp_ch.load_tile_y    <= req_q ? ty_q : '0;
            if (neg_q) begin
              rsp_ch.texture_number <= '0;
            end else if (hires_q) begin
              rsp_ch.texture_number <= ttc_pkg::TEX_W'(slot_q);
            end else begin
              rsp_ch.texture_number <= ttc_pkg::TEX_W'(NUM_SLOTS + 32'(coarse_q));
            end
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_IMPL(a_no_accept_in_clear, state == ttc_pkg::ST_CLEAR, !req_ch.ready, "accept in clear")
  `ASSERT_IMPL(a_evict_has_load, rsp_ch.valid && rsp_ch.evicted, rsp_ch.load_request, "evict w/o load")
  `ASSERT_IMPL(a_load_not_hires, rsp_ch.valid && rsp_ch.load_request, !rsp_ch.is_hires, "new slot ready")
  `ASSERT_NEXT(a_alloc_sets_valid, state == ttc_pkg::ST_ALLOC, slot_valid[slot_q], "slot not valid")
endmodule

// File: rtl/core/ttc_tile_tbl.sv
// tile to slot table: one write port, one registered read port
// no dependencies
module ttc_tile_tbl #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int SW = 6
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] waddr,
  input  logic [SW:0]                      wdata,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] raddr,
  output logic [SW:0]                      rdata
);
  logic [SW:0] mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/ttc_slot_mem.sv
// per-slot stamp and tile memories, each one write and one registered read
// depends on ttc_pkg
module ttc_slot_mem #(
  parameter int NUM_SLOTS = 64,
  parameter int TW = 10
) (
  input  logic                          clk,
  input  logic                          stamp_we,
  input  logic [$clog2(NUM_SLOTS)-1:0]  stamp_waddr,
  input  logic [ttc_pkg::STAMP_W-1:0]   stamp_wdata,
  input  logic [$clog2(NUM_SLOTS)-1:0]  stamp_raddr,
  output logic [ttc_pkg::STAMP_W-1:0]   stamp_rdata,
  input  logic                          tile_we,
  input  logic [$clog2(NUM_SLOTS)-1:0]  tile_waddr,
  input  logic [TW-1:0]                 tile_wdata,
  input  logic [$clog2(NUM_SLOTS)-1:0]  tile_raddr,
  output logic [TW-1:0]                 tile_rdata
);
  logic [ttc_pkg::STAMP_W-1:0] stamp_mem [NUM_SLOTS];
  logic [TW-1:0]               tile_mem [NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (stamp_we) begin
      stamp_mem[stamp_waddr] <= stamp_wdata;
    end
    stamp_rdata <= stamp_mem[stamp_raddr];
  end

  always_ff @(posedge clk) begin
    if (tile_we) begin
      tile_mem[tile_waddr] <= tile_wdata;
    end
    tile_rdata <= tile_mem[tile_raddr];
  end
endmodule

// File: tb/ttc_scoreboard.sv
// checker for the tile texture cache lookup: watches config, request and result channels,
// keeps its own copy of the cache state, predicts each result word and compares it
// depends on ttc_pkg, ttc_req_if and ttc_rsp_if
module ttc_scoreboard #(
  parameter int NUM_SLOTS = 64,
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [ttc_pkg::LOG_W-1:0] cfg_data,
  ttc_req_if                        req,
  ttc_rsp_if                        rsp,
  output int                        errors,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ttc_pkg::*;

  typedef struct packed {
    logic [TEX_W-1:0]   texture_number;
    logic               is_hires;
    logic               load_request;
    logic [LSLOT_W-1:0] load_slot;
    logic [TILE_W-1:0]  load_tile_x;
    logic [TILE_W-1:0]  load_tile_y;
    logic               evicted;
  } answer_t;

  answer_t answers[$];
  logic [LOG_W-1:0] width_log2, height_log2;
  logic slot_used[NUM_SLOTS];
  logic slot_loaded[NUM_SLOTS];
  logic [31:0] slot_tile_no[NUM_SLOTS];
  logic [STAMP_W-1:0] slot_stamp[NUM_SLOTS];
  logic tile_mapped[TABLE_ENTRIES];
  int tile_slot[TABLE_ENTRIES];
  logic [STAMP_W-1:0] frame;

  assign pending = answers.size();

  function automatic answer_t cache_lookup(logic [15:0] xr, logic [15:0] yr);
    answer_t a;
    logic [31:0] x, y, sh, tx, ty, tile, lim, cx, cy;
    int slot, best;
    logic have, fresh, gone;
    a = '0;
    if (xr[15] || yr[15]) return a;
    x = {16'd0, xr};
    y = {16'd0, yr};
    sh = (width_log2 >= 5) ? width_log2 - 5 : 0;
    tx = x >> sh;
    ty = y >> sh;
    tile = (ty * 32 + tx) % TABLE_ENTRIES;
    have = 0;
    fresh = 0;
    gone = 0;
    slot = NUM_SLOTS;
    if (tile_mapped[tile]) begin
      slot = tile_slot[tile];
      have = 1;
    end else begin
      lim = frame - 32'd2;
      best = NUM_SLOTS;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!slot_used[i]) begin
          slot = i;
          break;
        end
        if (slot_stamp[i] < lim) begin
          lim = slot_stamp[i];
          best = i;
        end
      end
      if (slot == NUM_SLOTS && best < NUM_SLOTS) begin
        tile_mapped[slot_tile_no[best] % TABLE_ENTRIES] = 0;
        slot_loaded[best] = 0;
        gone = 1;
        slot = best;
      end
      if (slot < NUM_SLOTS) begin
        have = 1;
        fresh = 1;
        slot_used[slot] = 1;
        slot_loaded[slot] = 0;
        slot_tile_no[slot] = tile;
        tile_mapped[tile] = 1;
        tile_slot[tile] = slot;
      end
    end
    if (have) slot_stamp[slot] = frame;
    if (have && slot_loaded[slot]) begin
      a.texture_number = TEX_W'(slot);
      a.is_hires = 1;
    end else begin
      cx = (x * 4) >> width_log2;
      cy = (y * 4) >> height_log2;
      a.texture_number = TEX_W'(NUM_SLOTS + ((cy * 4 + cx) % 16));
    end
    if (fresh) begin
      a.load_request = 1;
      a.load_slot = LSLOT_W'(slot);
      a.load_tile_x = tx[TILE_W-1:0];
      a.load_tile_y = ty[TILE_W-1:0];
    end
    a.evicted = gone;
    return a;
  endfunction

  task automatic field_check(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s expected %0d got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    answer_t w;
    if (rst) begin
      width_log2 <= LOG2_RESET;
      height_log2 <= LOG2_RESET;
      frame = FRAME_RESET;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_used[i] = 0;
        slot_loaded[i] = 0;
        slot_stamp[i] = '0;
        slot_tile_no[i] = 0;
      end
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        tile_mapped[i] = 0;
        tile_slot[i] = 0;
      end
      answers.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_WIDTH_LOG2) width_log2 <= cfg_data;
        else height_log2 <= cfg_data;
      end
      if (rsp.valid && rsp.ready) begin
        if (answers.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          w = answers.pop_front();
          field_check("texture_number", w.texture_number, rsp.texture_number);
          field_check("is_hires", w.is_hires, rsp.is_hires);
          field_check("load_request", w.load_request, rsp.load_request);
          field_check("load_slot", w.load_slot, rsp.load_slot);
          field_check("load_tile_x", w.load_tile_x, rsp.load_tile_x);
          field_check("load_tile_y", w.load_tile_y, rsp.load_tile_y);
          field_check("evicted", w.evicted, rsp.evicted);
        end
      end
      if (req.valid && req.ready) begin
        case (req.func)
          FN_LOOKUP: answers.push_back(cache_lookup(req.map_x, req.map_y));
          FN_TICK: frame = frame + 32'd1;
          FN_DONE: begin
            if (req.done_slot < NUM_SLOTS && slot_used[req.done_slot])
              slot_loaded[req.done_slot] = 1;
          end
          default: ;
        endcase
      end
    end
  end
endmodule

// File: tb/tb_tile_texture_cache_lookup_top.sv
// testbench top for the tile texture cache lookup: clock, reset, config phases,
// directed and random request words, result back-pressure and the verdict
// depends on ttc_pkg, ttc_req_if, ttc_rsp_if, ttc_scoreboard and the rtl top
module tb_tile_texture_cache_lookup_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ttc_pkg::*;

  localparam int SETTLE = 100;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic cfg_index = REG_WIDTH_LOG2;
  logic [LOG_W-1:0] cfg_data = '0;
  logic quiet = 0;
  logic hold_off = 0;
  logic [LOG_W-1:0] cur_width = LOG2_RESET;
  int errors, pending;

  ttc_req_if req();
  ttc_rsp_if rsp();

  initial begin
    req.valid = 0;
    req.func = FN_NONE;
    req.map_x = '0;
    req.map_y = '0;
    req.done_slot = '0;
    rsp.ready = 0;
  end

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  tile_texture_cache_lookup_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_ch(req), .rsp_ch(rsp)
  );

  ttc_scoreboard sb (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req), .rsp(rsp), .errors(errors), .pending(pending)
  );

  initial begin
    #30ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: random stall bursts, one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 0;
    end else if (hold_off) begin
      rsp.ready <= 0;
    end else if (quiet || $urandom_range(0, 3) != 0) begin
      rsp.ready <= 1;
    end else begin
      rsp.ready <= 0;
      repeat ($urandom_range(1, 8) - 1) @(posedge clk);
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [LOG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_WIDTH_LOG2) cur_width = val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // called at a rising edge; leaves valid high after the accepting edge
  task automatic send_word(func_t f, logic [15:0] x, logic [15:0] y, logic [5:0] d);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      req.valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    req.valid <= 1;
    req.func <= f;
    req.map_x <= x;
    req.map_y <= y;
    req.done_slot <= d;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic drain();
    req.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_word();
    int r, sh;
    logic [15:0] x, y;
    r = $urandom_range(0, 99);
    sh = (cur_width >= 5) ? cur_width - 5 : 0;
    x = $urandom;
    y = $urandom;
    if (r < 12) send_word(FN_TICK, x, y, $urandom);
    else if (r < 24) send_word(FN_DONE, x, y, $urandom);
    else if (r < 26) send_word(FN_NONE, x, y, $urandom);
    else if (r < 40) send_word(FN_LOOKUP, x, y, $urandom);
    else begin
      x = (16'($urandom_range(0, 15)) << sh) | (16'($urandom) & 16'((1 << sh) - 1));
      y = (16'($urandom_range(0, 7)) << sh) | (16'($urandom) & 16'((1 << sh) - 1));
      send_word(FN_LOOKUP, {1'b0, x[14:0]}, {1'b0, y[14:0]}, $urandom);
    end
  endtask

  initial begin
    logic [LOG_W-1:0] widths[4];
    logic [LOG_W-1:0] heights[4];
    widths = '{4'd0, 4'd15, 4'd5, 4'd10};
    heights = '{4'd2, 4'd15, 4'd0, 4'd7};
    repeat (8) @(posedge clk);
    rst <= 0;

    send_word(FN_LOOKUP, 16'h0000, 16'h0000, 6'd0);
    send_word(FN_LOOKUP, 16'h7fff, 16'h7fff, 6'd0);
    send_word(FN_LOOKUP, 16'h8000, 16'h0010, 6'd0);
    send_word(FN_LOOKUP, 16'h0010, 16'hffff, 6'd0);
    send_word(FN_DONE, 16'h0000, 16'h0000, 6'd0);
    send_word(FN_DONE, 16'h0000, 16'h0000, 6'd63);
    send_word(FN_LOOKUP, 16'h0000, 16'h0000, 6'd0);
    send_word(FN_NONE, 16'hffff, 16'hffff, 6'd63);
    send_word(FN_TICK, 16'h5555, 16'haaaa, 6'd21);
    send_word(FN_TICK, 16'haaaa, 16'h5555, 6'd42);
    send_word(FN_TICK, 16'h0000, 16'h0000, 6'd0);
    send_word(FN_LOOKUP, 16'h00ff, 16'h0100, 6'd0);
    drain();

    hold_off <= 1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off <= 0;
      end
      for (int i = 0; i < 70; i++) random_word();
    join

    for (int p = 0; p < 5; p++) begin
      drain();
      if (p < 4) begin
        write_reg(REG_WIDTH_LOG2, widths[p]);
        write_reg(REG_HEIGHT_LOG2, heights[p]);
      end else begin
        write_reg(REG_WIDTH_LOG2, LOG2_RESET);
        write_reg(REG_HEIGHT_LOG2, LOG2_RESET);
      end
      for (int i = 0; i < 400; i++) begin
        if (p == 4 && i >= 250) quiet = 1;
        random_word();
      end
    end
    drain();
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// File: tile_texture_cache_lookup_top.f
+incdir+rtl/core
rtl/core/ttc_pkg.sv
rtl/core/ttc_req_if.sv
rtl/core/ttc_rsp_if.sv
rtl/core/ttc_tile_tbl.sv
rtl/core/ttc_slot_mem.sv
rtl/core/tile_texture_cache_lookup_top.sv
tb/ttc_scoreboard.sv
tb/tb_tile_texture_cache_lookup_top.sv
